FILE: design/hxl_pkg.sv
// ----------------------------------------------------------------------------
// hxl_pkg: shared types and constants for the hex text configuration loader
// Holds the group size, character codes, the sequencer state type, the
// control structs between the submodules and the hex digit decoder.
// ----------------------------------------------------------------------------
package hxl_pkg;

  // Digits that close a group on their own.
  localparam int DIGITS_PER_GROUP = 8;
  // A group never counts past DIGITS_PER_GROUP digits, capped at sixteen.
  localparam int GROUP_LIMIT = (DIGITS_PER_GROUP < 16) ? DIGITS_PER_GROUP : 16;
  localparam int CNT_W = $clog2(GROUP_LIMIT + 1);

  localparam int WORD_W       = 32;
  localparam int NIBBLES      = 8;
  localparam int MAX_BITS     = 32;
  localparam int BIT_CNT_W    = 6;
  localparam int S_TDATA_W    = 16;
  localparam int M_TDATA_W    = 40;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } state_t;

  // Control of the digit packer.
  typedef struct packed {
    logic take;
    logic clear;
  } pack_ctl_t;

  // Control of the serial shifter.
  typedef struct packed {
    logic load;
    logic step;
  } shift_ctl_t;

  // Value of one hex character; anything that is not a hex digit counts as 0.
  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [3:0] v;
    v = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      v = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      v = 4'(ch - 8'h61 + 8'd10);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      v = 4'(ch - 8'h41 + 8'd10);
    end
    return v;
  endfunction

  // Serial bits for a group: four per digit, at most one full word.
  function automatic logic [BIT_CNT_W-1:0] bit_count(input logic [CNT_W-1:0] digits);
    logic [6:0] nb;
    nb = 7'(digits) << 2;
    if (nb > 7'(MAX_BITS)) begin
      return BIT_CNT_W'(MAX_BITS);
    end
    return nb[BIT_CNT_W-1:0];
  endfunction

endpackage

FILE: design/hxl_pack.sv
// ----------------------------------------------------------------------------
// hxl_pack: hex digit packer
// Keeps the word under assembly and the digit count of the current group.
// Digit pairs form bytes, high nibble first, bytes filling from the low end.
// ----------------------------------------------------------------------------
module hxl_pack (
  input  logic                      clk,
  input  logic                      rst,
  input  hxl_pkg::pack_ctl_t        ctl,
  input  logic [7:0]                char_code,
  output logic [hxl_pkg::WORD_W-1:0] word,
  output logic [hxl_pkg::CNT_W-1:0]  count,
  output logic [hxl_pkg::WORD_W-1:0] word_dig,
  output logic [hxl_pkg::CNT_W-1:0]  count_inc
);

  logic [4:0] cnt5;
  logic [2:0] nib_idx;
  logic [3:0] digit;

  // Word and count as they stand once the current character is taken.
  always_comb begin
    cnt5      = 5'(count);
    nib_idx   = {cnt5[2:1], ~cnt5[0]};
    digit     = hxl_pkg::hex_value(char_code);
    count_inc = count + hxl_pkg::CNT_W'(1);
    word_dig  = word;
    if (cnt5 < 5'd8) begin
      word_dig = word | (hxl_pkg::WORD_W'(digit) << {nib_idx, 2'b00});
    end
  end

  // A group end clears the packer, even when its last digit arrives with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      word  <= '0;
      count <= '0;
    end else if (ctl.clear) begin
      word  <= '0;
      count <= '0;
    end else if (ctl.take) begin
      word  <= word_dig;
      count <= count_inc;
    end
  end

endmodule

FILE: design/hxl_shift.sv
// ----------------------------------------------------------------------------
// hxl_shift: serial shifter
// Holds a copy of the finished word and shifts it out one bit per step,
// least significant bit first, counting down the bits that remain.
// ----------------------------------------------------------------------------
module hxl_shift (
  input  logic                          clk,
  input  logic                          rst,
  input  hxl_pkg::shift_ctl_t           ctl,
  input  logic [hxl_pkg::WORD_W-1:0]    load_word,
  input  logic [hxl_pkg::BIT_CNT_W-1:0] load_bits,
  output logic                          bit_out,
  output logic                          final_bit
);

  logic [hxl_pkg::WORD_W-1:0]    sh;
  logic [hxl_pkg::BIT_CNT_W-1:0] remain;

  // Bit register; payload only.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sh <= load_word;
    end else if (ctl.step) begin
      sh <= sh >> 1;
    end
  end

  // Count of bits still to go.
  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (ctl.load) begin
      remain <= load_bits;
    end else if (ctl.step) begin
      remain <= remain - hxl_pkg::BIT_CNT_W'(1);
    end
  end

  assign bit_out   = sh[0];
  assign final_bit = (remain == hxl_pkg::BIT_CNT_W'(1));

endmodule

FILE: design/hex_text_fpga_config_loader.sv
// ----------------------------------------------------------------------------
// hex_text_fpga_config_loader: hex text to configuration data converter
// Timing: a word-mode result is valid in the cycle after its closing character
// is taken; in serial mode the word is loaded into the shifter, then each bit
// passes through the output register, one bit a cycle while the sink keeps up.
// Throughput: one character a cycle while the output register is free, except that
// the character closing a serial group keeps s_tready low until the one shifter
// has sent the group's last bit, one bit a cycle while the sink keeps up.
// Reset: synchronous; clears the packer, halt flag and output valid, serial mode on.
// ----------------------------------------------------------------------------
module hex_text_fpga_config_loader (
  input  logic        clk,
  input  logic        rst,
  // Configuration: bit 0 is serial_mode.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  // Input characters.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // char_code[7:0], init_flag[8], zero fill
  // Results.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_data[31:0], init_error[32], zero fill
  output logic        m_tuser,   // is_word
  output logic        m_tlast
);

  hxl_pkg::state_t   state, state_next;
  hxl_pkg::pack_ctl_t  pack_ctl;
  hxl_pkg::shift_ctl_t shift_ctl;

  logic                            serial_mode;
  logic                            halted;
  logic                            set_halt;
  logic [7:0]                      char_code;
  logic                            init_flag;
  logic [hxl_pkg::WORD_W-1:0]      word, word_dig, em_word;
  logic [hxl_pkg::CNT_W-1:0]       count, count_inc, em_cnt;
  logic                            bit_out, final_bit;
  logic                            out_free, accept, term, emit;
  logic                            out_load;
  logic [hxl_pkg::WORD_W-1:0]      out_data_next;
  logic                            out_err_next, out_word_next, out_last_next;

  assign char_code = s_tdata[7:0];
  assign init_flag = s_tdata[8];

  // Configuration register, always ready.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      serial_mode <= 1'b1;
    end else if (cfg_valid) begin
      serial_mode <= cfg_data;
    end
  end

  hxl_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .ctl       (pack_ctl),
    .char_code (char_code),
    .word      (word),
    .count     (count),
    .word_dig  (word_dig),
    .count_inc (count_inc)
  );

  hxl_shift u_shift (
    .clk       (clk),
    .rst       (rst),
    .ctl       (shift_ctl),
    .load_word (em_word),
    .load_bits (hxl_pkg::bit_count(em_cnt)),
    .bit_out   (bit_out),
    .final_bit (final_bit)
  );

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == hxl_pkg::ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  // Group end detection and the group it closes.
  always_comb begin
    term    = (char_code == hxl_pkg::CHAR_CR) || (char_code == hxl_pkg::CHAR_LF);
    em_word = term ? word : word_dig;
    em_cnt  = term ? count : count_inc;
    emit    = term ? (count != '0) : (count_inc >= hxl_pkg::CNT_W'(hxl_pkg::GROUP_LIMIT));
  end

  // Sequencer: next state, packer and shifter control, output loading.
  always_comb begin
    state_next     = state;
    pack_ctl       = '0;
    shift_ctl      = '0;
    set_halt       = 1'b0;
    out_load       = 1'b0;
    out_data_next  = '0;
    out_err_next   = 1'b0;
    out_word_next  = 1'b0;
    out_last_next  = 1'b0;
    unique case (state)
      hxl_pkg::ST_IDLE: begin
        if (accept && !halted) begin
          pack_ctl.take  = !term;
          pack_ctl.clear = emit;
          if (emit && serial_mode) begin
            shift_ctl.load = 1'b1;
            state_next     = hxl_pkg::ST_SHIFT;
          end else if (emit) begin
            out_load      = 1'b1;
            out_data_next = em_word;
            out_word_next = 1'b1;
            out_err_next  = !init_flag;
            out_last_next = 1'b1;
            set_halt      = !init_flag;
          end
        end
      end
      hxl_pkg::ST_SHIFT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_data_next  = hxl_pkg::WORD_W'(bit_out);
          out_last_next  = final_bit;
          shift_ctl.step = 1'b1;
          if (final_bit) begin
            state_next = hxl_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = hxl_pkg::ST_IDLE;
      end
    endcase
  end

  // State and halt flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= hxl_pkg::ST_IDLE;
      halted <= 1'b0;
    end else begin
      state <= state_next;
      if (set_halt) begin
        halted <= 1'b1;
      end
    end
  end

  // Output register: valid flag under reset, payload without.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'b0, out_err_next, out_data_next};
      m_tuser <= out_word_next;
      m_tlast <= out_last_next;
    end
  end

  // The input is held off while bits are being shifted out.
  assert property (@(posedge clk) disable iff (rst)
    (state == hxl_pkg::ST_SHIFT) |-> !s_tready)
    else $error("input accepted during serial shift");

  // A serial result carries one bit and never an init error.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[39:1] == 39'b0))
    else $error("serial result carries more than one bit");

  // A word result always closes its character.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("word result without last");

  // The halt after an init error holds until reset.
  assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt released without reset");

endmodule
